[rtl/dtwg_pkg.sv]
// ----------------------------------------------------------------------------
// dtwg_pkg
// Shared types, constants and the sine quarter-wave table for the
// dual-table waveform generator.
// ----------------------------------------------------------------------------
package dtwg_pkg;

  localparam int TABLE_POINTS_DEF        = 256;
  localparam int PHASE_FRACTION_BITS_DEF = 16;

  localparam int PHASE_W     = 24;
  localparam int STEP_W      = 23;
  localparam int CODE_W      = 16;
  localparam int SHAPE_W     = 2;
  localparam int OUT_INDEX_W = 8;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 23;
  localparam int SVAL_W      = 17;   // Q1.15 plus room for +1.0
  localparam int PROD_W      = 34;
  localparam int ROUND_SHIFT = 15;

  localparam logic signed [SVAL_W-1:0] SHAPE_ONE = 17'sd32768;

  typedef enum logic [SHAPE_W-1:0] {
    SHAPE_SINE     = 2'd0,
    SHAPE_TRIANGLE = 2'd1,
    SHAPE_SQUARE   = 2'd2
  } shape_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CH0_SHAPE      = 4'd0,
    REG_CH1_SHAPE      = 4'd1,
    REG_CH0_AMPLITUDE  = 4'd2,
    REG_CH0_MEAN       = 4'd3,
    REG_CH1_AMPLITUDE  = 4'd4,
    REG_CH1_MEAN       = 4'd5,
    REG_CH0_PHASE_STEP = 4'd6,
    REG_CH1_PHASE_STEP = 4'd7
  } reg_index_t;

  // Pipeline advance enables, one per stage after the phase stage.
  typedef struct packed {
    logic en_b;
    logic en_c;
    logic en_d;
  } pipe_ctrl_t;

  localparam int QROM_LAST = 64;

  localparam logic [15:0] QUARTER_ROM [QROM_LAST+1] = '{
    16'd0,     16'd804,   16'd1608,  16'd2410,  16'd3212,  16'd4011,  16'd4808,  16'd5602,
    16'd6393,  16'd7179,  16'd7962,  16'd8739,  16'd9512,  16'd10278, 16'd11039, 16'd11793,
    16'd12539, 16'd13279, 16'd14010, 16'd14732, 16'd15446, 16'd16151, 16'd16846, 16'd17530,
    16'd18204, 16'd18868, 16'd19519, 16'd20159, 16'd20787, 16'd21403, 16'd22005, 16'd22594,
    16'd23170, 16'd23731, 16'd24279, 16'd24811, 16'd25329, 16'd25832, 16'd26319, 16'd26790,
    16'd27245, 16'd27683, 16'd28105, 16'd28510, 16'd28898, 16'd29268, 16'd29621, 16'd29956,
    16'd30273, 16'd30571, 16'd30852, 16'd31113, 16'd31356, 16'd31580, 16'd31785, 16'd31971,
    16'd32137, 16'd32285, 16'd32412, 16'd32521, 16'd32609, 16'd32678, 16'd32728, 16'd32757,
    16'd32767
  };

  function automatic logic [15:0] quarter_rom(input logic [6:0] k);
    logic [15:0] q;
    if (k > 7'(QROM_LAST)) begin
      q = QUARTER_ROM[QROM_LAST];
    end else begin
      q = QUARTER_ROM[k];
    end
    return q;
  endfunction

endpackage

[rtl/dual_table_waveform_generator.sv]
// ----------------------------------------------------------------------------
// dual_table_waveform_generator
// Two-channel DDS function generator: sine, triangle or square per channel.
// ----------------------------------------------------------------------------
// Each tick transaction advances both phase accumulators by their phase
// steps (restart clears them first) and yields one sample transaction with
// both DAC codes and table indices. One tick is taken every clock cycle
// unless the pipeline is full and stalled. The rate is set by the phase RAM
// read-modify-write loop, which closes through a forwarding register. The
// pipeline is four stages (phase, shape, multiply, round/clamp); a stalled
// sample holds the output register while empty stages upstream keep
// accepting ticks. Configuration writes are always ready and take effect on
// the next tick; write them while idle.
// TABLE_POINTS must be a power of two.
// ----------------------------------------------------------------------------
module dual_table_waveform_generator #(
  parameter int TABLE_POINTS        = dtwg_pkg::TABLE_POINTS_DEF,
  parameter int PHASE_FRACTION_BITS = dtwg_pkg::PHASE_FRACTION_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // tick channel
  input  logic                             tick_valid,
  output logic                             tick_stall,
  input  logic                             restart,
  // sample channel
  output logic                             sample_valid,
  input  logic                             sample_stall,
  output logic [dtwg_pkg::CODE_W-1:0]      dac0_code,
  output logic [dtwg_pkg::CODE_W-1:0]      dac1_code,
  output logic [dtwg_pkg::OUT_INDEX_W-1:0] ch0_index,
  output logic [dtwg_pkg::OUT_INDEX_W-1:0] ch1_index,
  // configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [dtwg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dtwg_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int IDX_W = $clog2(TABLE_POINTS);

  // configuration registers
  logic [dtwg_pkg::SHAPE_W-1:0] ch0_shape, ch1_shape;
  logic [dtwg_pkg::CODE_W-1:0]  ch0_amplitude, ch0_mean, ch1_amplitude, ch1_mean;
  logic [dtwg_pkg::STEP_W-1:0]  ch0_phase_step, ch1_phase_step;

  // stage valids: a = phase, b = shape, c = product, d = output
  logic v_a, v_b, v_c, v_d;
  logic en_a;
  logic accept;
  dtwg_pkg::pipe_ctrl_t ctrl;

  logic [IDX_W-1:0] idx0_a, idx1_a, idx0_b, idx1_b, idx0_d, idx1_d;
  logic signed [dtwg_pkg::SVAL_W-1:0] sval0_b, sval1_b;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ch0_shape      <= '0;
      ch1_shape      <= '0;
      ch0_amplitude  <= '0;
      ch0_mean       <= '0;
      ch1_amplitude  <= '0;
      ch1_mean       <= '0;
      ch0_phase_step <= '0;
      ch1_phase_step <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (dtwg_pkg::reg_index_t'(cfg_index))
        dtwg_pkg::REG_CH0_SHAPE:      ch0_shape      <= cfg_data[dtwg_pkg::SHAPE_W-1:0];
        dtwg_pkg::REG_CH1_SHAPE:      ch1_shape      <= cfg_data[dtwg_pkg::SHAPE_W-1:0];
        dtwg_pkg::REG_CH0_AMPLITUDE:  ch0_amplitude  <= cfg_data[dtwg_pkg::CODE_W-1:0];
        dtwg_pkg::REG_CH0_MEAN:       ch0_mean       <= cfg_data[dtwg_pkg::CODE_W-1:0];
        dtwg_pkg::REG_CH1_AMPLITUDE:  ch1_amplitude  <= cfg_data[dtwg_pkg::CODE_W-1:0];
        dtwg_pkg::REG_CH1_MEAN:       ch1_mean       <= cfg_data[dtwg_pkg::CODE_W-1:0];
        dtwg_pkg::REG_CH0_PHASE_STEP: ch0_phase_step <= cfg_data[dtwg_pkg::STEP_W-1:0];
        dtwg_pkg::REG_CH1_PHASE_STEP: ch1_phase_step <= cfg_data[dtwg_pkg::STEP_W-1:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // A stage moves when it is empty or the next stage moves; bubbles
  // collapse, so ticks keep coming while a sample waits at the output.
  always_comb begin
    ctrl.en_d = !v_d || !sample_stall;
    ctrl.en_c = !v_c || ctrl.en_d;
    ctrl.en_b = !v_b || ctrl.en_c;
    en_a      = !v_a || ctrl.en_b;
  end

  assign tick_stall   = !en_a;
  assign accept       = tick_valid && !tick_stall;
  assign sample_valid = v_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      v_b <= 1'b0;
      v_c <= 1'b0;
      v_d <= 1'b0;
    end else begin
      if (en_a) begin
        v_a <= tick_valid;
      end
      if (ctrl.en_b) begin
        v_b <= v_a;
      end
      if (ctrl.en_c) begin
        v_c <= v_b;
      end
      if (ctrl.en_d) begin
        v_d <= v_c;
      end
    end
  end

  // phase stage: RAM-held accumulators, index registered on accept
  dtwg_phase #(
    .TABLE_POINTS        (TABLE_POINTS),
    .PHASE_FRACTION_BITS (PHASE_FRACTION_BITS)
  ) u_phase (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .restart (restart),
    .step0   (ch0_phase_step),
    .step1   (ch1_phase_step),
    .idx0    (idx0_a),
    .idx1    (idx1_a)
  );

  // shape stage, one per channel
  dtwg_shape #(.TABLE_POINTS (TABLE_POINTS)) u_shape0 (
    .clk       (clk),
    .ctrl      (ctrl),
    .shape     (ch0_shape),
    .idx       (idx0_a),
    .shape_val (sval0_b),
    .idx_q     (idx0_b)
  );

  dtwg_shape #(.TABLE_POINTS (TABLE_POINTS)) u_shape1 (
    .clk       (clk),
    .ctrl      (ctrl),
    .shape     (ch1_shape),
    .idx       (idx1_a),
    .shape_val (sval1_b),
    .idx_q     (idx1_b)
  );

  // multiply and round/clamp stages, one per channel
  dtwg_scale #(.TABLE_POINTS (TABLE_POINTS)) u_scale0 (
    .clk       (clk),
    .ctrl      (ctrl),
    .amplitude (ch0_amplitude),
    .mean      (ch0_mean),
    .shape_val (sval0_b),
    .idx       (idx0_b),
    .code      (dac0_code),
    .idx_q     (idx0_d)
  );

  dtwg_scale #(.TABLE_POINTS (TABLE_POINTS)) u_scale1 (
    .clk       (clk),
    .ctrl      (ctrl),
    .amplitude (ch1_amplitude),
    .mean      (ch1_mean),
    .shape_val (sval1_b),
    .idx       (idx1_b),
    .code      (dac1_code),
    .idx_q     (idx1_d)
  );

  // index field carries the low bits of the table index
  assign ch0_index = dtwg_pkg::OUT_INDEX_W'(idx0_d);
  assign ch1_index = dtwg_pkg::OUT_INDEX_W'(idx1_d);

  // a stall at the tick side only comes from a full, stalled pipeline
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    tick_stall |-> (v_a && v_b && v_c && sample_valid && sample_stall))
    else $error("tick stalled with room in the pipeline");

  // an accepted tick occupies the phase stage next cycle
  a_accept_fill: assert property (@(posedge clk) disable iff (rst)
    accept |=> v_a)
    else $error("accepted tick lost at phase stage");

  // phase stage index stays inside the table
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    accept |=> ((32'(idx0_a) < TABLE_POINTS) && (32'(idx1_a) < TABLE_POINTS)))
    else $error("table index out of range");

  // a full product stage with an empty output stage presents a sample
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (v_c && !v_d) |=> sample_valid)
    else $error("product stage did not advance to output");

endmodule

[rtl/dtwg_ram.sv]
// ----------------------------------------------------------------------------
// dtwg_ram
// Generic single-write, single-read RAM with registered read (read-old).
// ----------------------------------------------------------------------------
module dtwg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/dtwg_phase.sv]
// ----------------------------------------------------------------------------
// dtwg_phase
// Phase accumulators for both channels, kept in the phase RAM.
// Read-modify-write every transaction, with forwarding of the last write.
// ----------------------------------------------------------------------------
module dtwg_phase #(
  parameter int TABLE_POINTS        = dtwg_pkg::TABLE_POINTS_DEF,
  parameter int PHASE_FRACTION_BITS = dtwg_pkg::PHASE_FRACTION_BITS_DEF,
  localparam int IDX_W = $clog2(TABLE_POINTS)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic                        restart,
  input  logic [dtwg_pkg::STEP_W-1:0] step0,
  input  logic [dtwg_pkg::STEP_W-1:0] step1,
  output logic [IDX_W-1:0]            idx0,
  output logic [IDX_W-1:0]            idx1
);

  localparam int PW = dtwg_pkg::PHASE_W;
  localparam logic [40:0] PHASE_LIMIT = 41'(TABLE_POINTS) << PHASE_FRACTION_BITS;

  logic [2*PW-1:0] rd_data;
  logic [2*PW-1:0] fwd_data;
  logic [2*PW-1:0] wr_data;
  logic [2*PW-1:0] cur;
  logic            wrote_last;
  logic            ram_loaded;
  logic [PW-1:0]   base0, base1, nxt0, nxt1;

  function automatic logic [PW-1:0] advance(input logic [PW-1:0] base,
                                            input logic [dtwg_pkg::STEP_W-1:0] step);
    logic [PW:0]   sum;
    logic [PW-1:0] r;
    sum = {1'b0, base} + (PW+1)'(step);
    if ((41'(sum) >= PHASE_LIMIT) || sum[PW]) begin
      r = '0;
    end else begin
      r = sum[PW-1:0];
    end
    return r;
  endfunction

  dtwg_ram #(
    .WIDTH (2*PW),
    .DEPTH (1)
  ) u_phase_ram (
    .clk   (clk),
    .we    (accept),
    .waddr ('0),
    .wdata (wr_data),
    .raddr ('0),
    .rdata (rd_data)
  );

  // RAM read data lags a write, so the last write is forwarded; never-written RAM reads as zero
  always_comb begin
    if (wrote_last) begin
      cur = fwd_data;
    end else if (ram_loaded) begin
      cur = rd_data;
    end else begin
      cur = '0;
    end
    base0   = restart ? '0 : cur[PW-1:0];
    base1   = restart ? '0 : cur[2*PW-1:PW];
    nxt0    = advance(base0, step0);
    nxt1    = advance(base1, step1);
    wr_data = {nxt1, nxt0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wrote_last <= 1'b0;
      ram_loaded <= 1'b0;
    end else begin
      wrote_last <= accept;
      if (accept) begin
        ram_loaded <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_data <= wr_data;
      idx0     <= IDX_W'(nxt0 >> PHASE_FRACTION_BITS);
      idx1     <= IDX_W'(nxt1 >> PHASE_FRACTION_BITS);
    end
  end

endmodule

[rtl/dtwg_shape.sv]
// ----------------------------------------------------------------------------
// dtwg_shape
// Shape stage: table index to Q1.15 shape value (sine, triangle, square).
// ----------------------------------------------------------------------------
module dtwg_shape #(
  parameter int TABLE_POINTS = dtwg_pkg::TABLE_POINTS_DEF,
  localparam int IDX_W = $clog2(TABLE_POINTS)
) (
  input  logic                                clk,
  input  dtwg_pkg::pipe_ctrl_t                ctrl,
  input  logic [dtwg_pkg::SHAPE_W-1:0]        shape,
  input  logic [IDX_W-1:0]                    idx,
  output logic signed [dtwg_pkg::SVAL_W-1:0]  shape_val,
  output logic [IDX_W-1:0]                    idx_q
);

  localparam int TURN_SH = 16 - IDX_W;

  logic [15:0] turn;
  logic [1:0]  quad;
  logic [14:0] pos;
  logic [6:0]  k;
  logic [7:0]  frac;
  logic [15:0] lo, hi, diff;
  logic [23:0] interp;
  logic [29:0] tri_prod;
  logic [15:0] mag_sin, mag_tri;
  logic signed [dtwg_pkg::SVAL_W-1:0] sin_s, tri_s, sval;

  always_comb begin
    turn     = 16'(32'(idx) << TURN_SH);
    quad     = turn[15:14];
    pos      = quad[0] ? (15'h4000 - {1'b0, turn[13:0]}) : {1'b0, turn[13:0]};
    k        = pos[14:8];
    frac     = pos[7:0];
    lo       = dtwg_pkg::quarter_rom(k);
    hi       = dtwg_pkg::quarter_rom(7'(k + 7'd1));
    diff     = hi - lo;
    interp   = diff * frac;
    mag_sin  = (k >= 7'(dtwg_pkg::QROM_LAST)) ? dtwg_pkg::quarter_rom(k)
                                              : 16'(lo + interp[23:8]);
    tri_prod = {pos, 15'b0} - 30'(pos);
    mag_tri  = 16'(tri_prod >> 14);
    sin_s    = quad[1] ? -$signed({1'b0, mag_sin}) : $signed({1'b0, mag_sin});
    tri_s    = quad[1] ? -$signed({1'b0, mag_tri}) : $signed({1'b0, mag_tri});
    case (dtwg_pkg::shape_t'(shape))
      dtwg_pkg::SHAPE_SINE:     sval = sin_s;
      dtwg_pkg::SHAPE_TRIANGLE: sval = tri_s;
      dtwg_pkg::SHAPE_SQUARE: begin
        sval = idx[IDX_W-1] ? dtwg_pkg::SHAPE_ONE : -dtwg_pkg::SHAPE_ONE;
      end
      default:                  sval = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.en_b) begin
      shape_val <= sval;
      idx_q     <= idx;
    end
  end

endmodule

[rtl/dtwg_scale.sv]
// ----------------------------------------------------------------------------
// dtwg_scale
// Scale stages: amplitude times shape, round, add mean, clamp to DAC range.
// ----------------------------------------------------------------------------
module dtwg_scale #(
  parameter int TABLE_POINTS = dtwg_pkg::TABLE_POINTS_DEF,
  localparam int IDX_W = $clog2(TABLE_POINTS)
) (
  input  logic                               clk,
  input  dtwg_pkg::pipe_ctrl_t               ctrl,
  input  logic [dtwg_pkg::CODE_W-1:0]        amplitude,
  input  logic [dtwg_pkg::CODE_W-1:0]        mean,
  input  logic signed [dtwg_pkg::SVAL_W-1:0] shape_val,
  input  logic [IDX_W-1:0]                   idx,
  output logic [dtwg_pkg::CODE_W-1:0]        code,
  output logic [IDX_W-1:0]                   idx_q
);

  localparam int RND_W = dtwg_pkg::PROD_W - dtwg_pkg::ROUND_SHIFT;

  logic signed [dtwg_pkg::PROD_W-1:0] prod;
  logic [IDX_W-1:0]                   idx_c;
  logic signed [dtwg_pkg::PROD_W-1:0] biased;
  logic signed [RND_W-1:0]            rounded;
  logic signed [RND_W:0]              level;
  logic [dtwg_pkg::CODE_W-1:0]        clamped;

  always_ff @(posedge clk) begin
    if (ctrl.en_c) begin
      prod  <= $signed({1'b0, amplitude}) * shape_val;
      idx_c <= idx;
    end
  end

  // round half up, then offset and saturate
  always_comb begin
    biased  = prod + dtwg_pkg::PROD_W'(1 << (dtwg_pkg::ROUND_SHIFT - 1));
    rounded = RND_W'(biased >>> dtwg_pkg::ROUND_SHIFT);
    level   = $signed({1'b0, (RND_W)'(mean)}) + (RND_W+1)'(rounded);
    if (level < 0) begin
      clamped = '0;
    end else if (level > $signed((RND_W+1)'({dtwg_pkg::CODE_W{1'b1}}))) begin
      clamped = '1;
    end else begin
      clamped = level[dtwg_pkg::CODE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en_d) begin
      code  <= clamped;
      idx_q <= idx_c;
    end
  end

endmodule
